// ===== rtl/core/patl_pkg.sv =====
`default_nettype none

package patl_pkg;

   localparam int PAGE_COUNT   = 32;
   localparam int FRAME_COUNT  = 8;
   localparam int OFFSET_BITS  = 7;
   localparam int PAGE_BITS    = $clog2(PAGE_COUNT);
   localparam int FRAME_BITS   = $clog2(FRAME_COUNT);
   localparam int LADDR_WIDTH  = 12;
   localparam int PADDR_WIDTH  = 10;
   localparam int STAMP_WIDTH  = 32;
   localparam int STEP_BITS    = 3;

   localparam logic [1:0] OUTCOME_HIT   = 2'd0;
   localparam logic [1:0] OUTCOME_FILL  = 2'd1;
   localparam logic [1:0] OUTCOME_EVICT = 2'd2;

   typedef logic [STEP_BITS-1:0] step_type;

   localparam step_type STEP_IDLE   = 3'd0;
   localparam step_type STEP_LOOKUP = 3'd1;
   localparam step_type STEP_SCAN   = 3'd2;
   localparam step_type STEP_SELECT = 3'd3;
   localparam step_type STEP_FILL   = 3'd4;
   localparam step_type STEP_FINISH = 3'd5;
   localparam int       STEP_COUNT  = 6;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_LOOKUP,
      OP_SCAN,
      OP_SELECT,
      OP_FILL,
      OP_FINISH
   } op_type;

   typedef enum logic [2:0] {
      COND_ALWAYS,
      COND_ACCEPT,
      COND_HIT,
      COND_SCAN_DONE,
      COND_RSP_FREE
   } cond_type;

   typedef struct packed {
      logic     req_ready;
      op_type   op;
      cond_type cond;
      step_type jump_true;
      step_type jump_false;
   } uword_type;

   // microprogram: next step is jump_true when cond holds, else jump_false
   localparam uword_type PROGRAM [STEP_COUNT] = '{
      '{1'b1, OP_NONE,   COND_ACCEPT,    STEP_LOOKUP, STEP_IDLE},
      '{1'b0, OP_LOOKUP, COND_HIT,       STEP_FINISH, STEP_SCAN},
      '{1'b0, OP_SCAN,   COND_SCAN_DONE, STEP_SELECT, STEP_SCAN},
      '{1'b0, OP_SELECT, COND_ALWAYS,    STEP_FILL,   STEP_FILL},
      '{1'b0, OP_FILL,   COND_ALWAYS,    STEP_FINISH, STEP_FINISH},
      '{1'b0, OP_FINISH, COND_RSP_FREE,  STEP_IDLE,   STEP_FINISH}
   };

endpackage

`default_nettype wire

// ===== rtl/core/patl_ram.sv =====
`default_nettype none

module patl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] storage_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         storage_ff[addr] <= wr_data;
      end
      rd_data_ff <= storage_ff[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/paged_address_translation_lru_top.sv =====
`default_nettype none

// channel   ports                                            direction
// req       req_valid, req_ready, req_logical_address[11:0]  in
// rsp       rsp_valid, rsp_ready, rsp_physical_address[9:0], out
//           rsp_outcome[1:0]
//
// Hit: accept, table read, result.
// Fault: accept, table read, frame scan, select, fill, result; the frame
// scan walks frames 1..7, one per cycle, stopping at the first free one.
// Reset clears page valid bits and stamps, sets frame 0 in use; no sweep.
// A result waits in the output register; the next item is taken meanwhile,
// and its last step holds until the register is free.

module paged_address_translation_lru_top (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [patl_pkg::LADDR_WIDTH-1:0]    req_logical_address,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic      [patl_pkg::PADDR_WIDTH-1:0]    rsp_physical_address,
   output logic      [1:0]                          rsp_outcome
);

   localparam int PB = patl_pkg::PAGE_BITS;
   localparam int FB = patl_pkg::FRAME_BITS;
   localparam int OB = patl_pkg::OFFSET_BITS;
   localparam int SW = patl_pkg::STAMP_WIDTH;
   localparam int FC = patl_pkg::FRAME_COUNT;
   localparam int PC = patl_pkg::PAGE_COUNT;

   patl_pkg::step_type  step_ff, step_in;
   patl_pkg::uword_type uword;
   logic                cond_true;

   logic [PC-1:0]  page_valid_ff, page_valid_in;
   logic [FC-1:0]  in_use_ff, in_use_in;
   logic [SW-1:0]  last_use_ff [FC];
   logic [SW-1:0]  last_use_in [FC];
   logic [SW-1:0]  clock_ff, clock_in;
   logic [PB-1:0]  owner_ff [FC];

   logic [PB-1:0]  page_ff, page_in;
   logic [OB-1:0]  offset_ff, offset_in;
   logic [FB-1:0]  frame_ff, frame_in;
   logic [1:0]     outcome_ff, outcome_in;
   logic [FB-1:0]  idx_ff, idx_in;
   logic [FB-1:0]  best_ff, best_in;
   logic [SW-1:0]  best_stamp_ff, best_stamp_in;
   logic           free_ff, free_in;

   logic                             rsp_valid_ff, rsp_valid_in;
   logic [patl_pkg::PADDR_WIDTH-1:0] rsp_paddr_ff, rsp_paddr_in;
   logic [1:0]                       rsp_outcome_ff, rsp_outcome_in;

   logic           ram_wr_en;
   logic [PB-1:0]  ram_addr;
   logic [FB-1:0]  ram_rd_data;
   logic           accept;
   logic           scan_done;
   logic           owner_wr;

   patl_ram #(
      .WIDTH(FB),
      .DEPTH(PC)
   ) u_page_frame (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .addr   (ram_addr),
      .wr_data(frame_ff),
      .rd_data(ram_rd_data)
   );

   assign uword     = patl_pkg::PROGRAM[step_ff];
   assign req_ready = uword.req_ready && !reset;
   assign accept    = req_valid && req_ready;
   assign scan_done = !in_use_ff[idx_ff] || (idx_ff == FB'(FC - 1));
   assign ram_wr_en = (uword.op == patl_pkg::OP_FILL);
   assign ram_addr  = ram_wr_en ? page_ff : req_logical_address[OB +: PB];
   assign owner_wr  = (uword.op == patl_pkg::OP_FILL);

   always_comb begin
      case (uword.cond)
         patl_pkg::COND_ALWAYS:    cond_true = 1'b1;
         patl_pkg::COND_ACCEPT:    cond_true = accept;
         patl_pkg::COND_HIT:       cond_true = page_valid_ff[page_ff];
         patl_pkg::COND_SCAN_DONE: cond_true = scan_done;
         patl_pkg::COND_RSP_FREE:  cond_true = !rsp_valid_ff || rsp_ready;
         default:                  cond_true = 1'b0;
      endcase
   end

   always_comb begin
      step_in        = cond_true ? uword.jump_true : uword.jump_false;
      page_valid_in  = page_valid_ff;
      in_use_in      = in_use_ff;
      last_use_in    = last_use_ff;
      clock_in       = clock_ff;
      page_in        = page_ff;
      offset_in      = offset_ff;
      frame_in       = frame_ff;
      outcome_in     = outcome_ff;
      idx_in         = idx_ff;
      best_in        = best_ff;
      best_stamp_in  = best_stamp_ff;
      free_in        = free_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_paddr_in   = rsp_paddr_ff;
      rsp_outcome_in = rsp_outcome_ff;

      case (uword.op)
         patl_pkg::OP_NONE: begin
            if (accept) begin
               page_in   = req_logical_address[OB +: PB];
               offset_in = req_logical_address[OB-1:0];
               if (clock_ff != '1) begin
                  clock_in = clock_ff + SW'(1);
               end
            end
         end
         patl_pkg::OP_LOOKUP: begin
            frame_in   = ram_rd_data;
            outcome_in = patl_pkg::OUTCOME_HIT;
            idx_in     = FB'(1);
            free_in    = 1'b0;
         end
         patl_pkg::OP_SCAN: begin
            if (!in_use_ff[idx_ff]) begin
               frame_in   = idx_ff;
               free_in    = 1'b1;
               outcome_in = patl_pkg::OUTCOME_FILL;
            end else if (idx_ff == FB'(1) || last_use_ff[idx_ff] < best_stamp_ff) begin
               best_in       = idx_ff;
               best_stamp_in = last_use_ff[idx_ff];
            end
            idx_in = idx_ff + FB'(1);
         end
         patl_pkg::OP_SELECT: begin
            if (!free_ff) begin
               frame_in                      = best_ff;
               outcome_in                    = patl_pkg::OUTCOME_EVICT;
               page_valid_in[owner_ff[best_ff]] = 1'b0;
            end
         end
         patl_pkg::OP_FILL: begin
            page_valid_in[page_ff] = 1'b1;
            in_use_in[frame_ff]    = 1'b1;
         end
         patl_pkg::OP_FINISH: begin
            if (cond_true) begin
               last_use_in[frame_ff] = clock_ff;
               rsp_valid_in          = 1'b1;
               rsp_paddr_in          = {frame_ff, offset_ff};
               rsp_outcome_in        = outcome_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff       <= patl_pkg::STEP_IDLE;
         page_valid_ff <= '0;
         in_use_ff     <= FC'(1);
         last_use_ff   <= '{default: '0};
         clock_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         step_ff       <= step_in;
         page_valid_ff <= page_valid_in;
         in_use_ff     <= in_use_in;
         last_use_ff   <= last_use_in;
         clock_ff      <= clock_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      page_ff        <= page_in;
      offset_ff      <= offset_in;
      frame_ff       <= frame_in;
      outcome_ff     <= outcome_in;
      idx_ff         <= idx_in;
      best_ff        <= best_in;
      best_stamp_ff  <= best_stamp_in;
      free_ff        <= free_in;
      rsp_paddr_ff   <= rsp_paddr_in;
      rsp_outcome_ff <= rsp_outcome_in;
      if (owner_wr) begin
         owner_ff[frame_ff] <= page_ff;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_physical_address = rsp_paddr_ff;
   assign rsp_outcome          = rsp_outcome_ff;

endmodule

`default_nettype wire

// ===== tb/tb_paged_address_translation_lru_top.sv =====
`default_nettype none

module tb_paged_address_translation_lru_top;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int HOLD_CYCLES    = 300;
   localparam int DRAIN_CYCLES   = 24;

   localparam int LAW = patl_pkg::LADDR_WIDTH;
   localparam int PAW = patl_pkg::PADDR_WIDTH;
   localparam int PB  = patl_pkg::PAGE_BITS;
   localparam int FB  = patl_pkg::FRAME_BITS;
   localparam int OB  = patl_pkg::OFFSET_BITS;
   localparam int SW  = patl_pkg::STAMP_WIDTH;
   localparam int PC  = patl_pkg::PAGE_COUNT;
   localparam int FC  = patl_pkg::FRAME_COUNT;

   typedef struct {
      logic [PAW-1:0] paddr;
      logic [1:0]     outcome;
   } translation_type;

   typedef struct {
      logic [LAW-1:0] laddr;
      bit             typed;
      logic [PAW-1:0] paddr;
      logic [1:0]     outcome;
   } vector_row_type;

   logic           clock;
   logic           reset;
   logic           req_valid;
   logic           req_ready;
   logic [LAW-1:0] req_logical_address;
   logic           rsp_valid;
   logic           rsp_ready;
   logic [PAW-1:0] rsp_physical_address;
   logic [1:0]     rsp_outcome;

   // predictor state
   logic           page_live    [PC];
   logic [FB-1:0]  page_to_frame[PC];
   logic           frame_busy   [FC];
   logic [SW-1:0]  frame_stamp  [FC];
   logic [PB-1:0]  frame_owner  [FC];
   logic [SW-1:0]  use_clock;

   translation_type pending_translations[$];
   translation_type oldest;
   int              failures = 0;
   int              quiet_cycles = 0;
   int              send_idle_pct = 0;
   int              stall_pct = 0;
   int              hold_ticket = 0;
   int              hold_seen = 0;
   int              hold_left = 0;

   vector_row_type  directed_rows[16];

   paged_address_translation_lru_top u_top (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_logical_address  (req_logical_address),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_physical_address (rsp_physical_address),
      .rsp_outcome          (rsp_outcome)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic void clear_translation_state();
      for (int p = 0; p < PC; p++) begin
         page_live[p]     = 1'b0;
         page_to_frame[p] = '0;
      end
      for (int f = 0; f < FC; f++) begin
         frame_busy[f]  = (f == 0);
         frame_stamp[f] = '0;
         frame_owner[f] = '0;
      end
      use_clock = '0;
   endfunction

   function automatic translation_type translate_address(input logic [LAW-1:0] la);
      translation_type res;
      logic [PB-1:0]   page;
      logic [FB-1:0]   frame;
      logic [FB-1:0]   victim;
      bit              found;
      page  = la[OB +: PB];
      found = 1'b0;
      frame = '0;
      if (use_clock != '1)
         use_clock = use_clock + SW'(1);
      if (page_live[page]) begin
         frame       = page_to_frame[page];
         res.outcome = patl_pkg::OUTCOME_HIT;
      end else begin
         for (int f = 1; f < FC; f++) begin
            if (!found && !frame_busy[f]) begin
               found = 1'b1;
               frame = FB'(f);
            end
         end
         if (found) begin
            frame_busy[frame] = 1'b1;
            res.outcome       = patl_pkg::OUTCOME_FILL;
         end else begin
            victim = FB'(1);
            for (int f = 2; f < FC; f++)
               if (frame_stamp[f] < frame_stamp[victim])
                  victim = FB'(f);
            frame                   = victim;
            page_live[frame_owner[frame]] = 1'b0;
            res.outcome             = patl_pkg::OUTCOME_EVICT;
         end
         page_to_frame[page] = frame;
         page_live[page]     = 1'b1;
         frame_owner[frame]  = page;
      end
      frame_stamp[frame] = use_clock;
      res.paddr = {frame, la[OB-1:0]};
      return res;
   endfunction

   // called at a falling edge; returns at the falling edge after the transfer
   task automatic send_address(input logic [LAW-1:0] la, input bit typed,
                               input logic [PAW-1:0] paddr, input logic [1:0] outcome);
      translation_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         req_logical_address <= LAW'($urandom);
         @(negedge clock);
      end
      req_valid           <= 1'b1;
      req_logical_address <= la;
      do @(posedge clock); while (!req_ready);
      predicted = translate_address(la);
      if (typed) begin
         predicted.paddr   = paddr;
         predicted.outcome = outcome;
      end
      pending_translations.push_back(predicted);
      @(negedge clock);
   endtask

   function automatic logic [LAW-1:0] random_address();
      logic [PB-1:0] page;
      case ($urandom_range(3))
         0, 1: page = PB'($urandom_range(8));
         2:    page = PB'($urandom_range(PC - 1, PC - 6));
         default: page = PB'($urandom_range(PC - 1));
      endcase
      return {page, OB'($urandom_range((1 << OB) - 1))};
   endfunction

   // receiver: random stalls, plus a long hold-off when one is requested
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_seen != hold_ticket) begin
            hold_seen = hold_ticket;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_translations.size() == 0) begin
            $error("result with no pending translation: physical_address %h outcome %0d",
                   rsp_physical_address, rsp_outcome);
            failures++;
         end else begin
            oldest = pending_translations.pop_front();
            if (rsp_physical_address !== oldest.paddr) begin
               $error("physical_address expected %h actual %h",
                      oldest.paddr, rsp_physical_address);
               failures++;
            end
            if (rsp_outcome !== oldest.outcome) begin
               $error("outcome expected %0d actual %0d", oldest.outcome, rsp_outcome);
               failures++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      int phase_items[5];
      int phase_idle[5];
      int phase_stall[5];

      phase_items = '{130, 120, 120, 130, 130};
      phase_idle  = '{0, 84, 0, 28, 0};
      phase_stall = '{0, 0, 84, 28, 0};

      directed_rows = '{
         '{12'h000, 1'b1, 10'h080, patl_pkg::OUTCOME_FILL},
         '{12'hFFF, 1'b1, 10'h17F, patl_pkg::OUTCOME_FILL},
         '{12'h07F, 1'b1, 10'h0FF, patl_pkg::OUTCOME_HIT},
         '{12'h080, 1'b1, 10'h180, patl_pkg::OUTCOME_FILL},
         '{12'h100, 1'b1, 10'h200, patl_pkg::OUTCOME_FILL},
         '{12'h180, 1'b1, 10'h280, patl_pkg::OUTCOME_FILL},
         '{12'h200, 1'b1, 10'h300, patl_pkg::OUTCOME_FILL},
         '{12'h255, 1'b1, 10'h355, patl_pkg::OUTCOME_HIT},
         '{12'h280, 1'b1, 10'h380, patl_pkg::OUTCOME_FILL},
         '{12'h300, 1'b0, '0, patl_pkg::OUTCOME_HIT},
         '{12'hFAA, 1'b0, '0, patl_pkg::OUTCOME_HIT},
         '{12'h001, 1'b0, '0, patl_pkg::OUTCOME_HIT},
         '{12'h7FF, 1'b0, '0, patl_pkg::OUTCOME_HIT},
         '{12'h800, 1'b0, '0, patl_pkg::OUTCOME_HIT},
         '{12'hAAA, 1'b0, '0, patl_pkg::OUTCOME_HIT},
         '{12'h555, 1'b0, '0, patl_pkg::OUTCOME_HIT}
      };

      reset               = 1'b1;
      req_valid           = 1'b0;
      req_logical_address = '0;
      clear_translation_state();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i])
         send_address(directed_rows[i].laddr, directed_rows[i].typed,
                      directed_rows[i].paddr, directed_rows[i].outcome);

      for (int ph = 0; ph < 5; ph++) begin
         send_idle_pct = phase_idle[ph];
         stall_pct     = phase_stall[ph];
         if (ph == 4)
            hold_ticket++;
         for (int n = 0; n < phase_items[ph]; n++)
            send_address(random_address(), 1'b0, '0, patl_pkg::OUTCOME_HIT);
      end
      req_valid <= 1'b0;

      while (pending_translations.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_translations.size() != 0) begin
         $error("%0d translations never returned", pending_translations.size());
         failures++;
      end

      if (failures == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

`default_nettype wire
